// ===== hdl/bbals_pkg.sv =====
package bbals_pkg;

    localparam int ACC_W       = 68;
    localparam int OPB_W       = 48;
    localparam int OPA_W       = 17;
    localparam int PROD_W      = OPA_W + OPB_W;
    localparam int BOUNCE_FRAC = 16;
    localparam logic signed [OPA_W-1:0] BOUNCE_COEF = -17'sd39322;
    localparam int NUM_UOPS    = 19;
    localparam int CNT_W       = 5;
    localparam int CFG_IDX_W   = 3;

    localparam logic signed [ACC_W-1:0] S32_MAX = 68'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] S32_MIN = -68'sh0_0000_0000_8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_X, CFG_LINE_Y, CFG_COS, CFG_SIN,
        CFG_LEFT, CFG_WIDTH, CFG_RADIUS, CFG_GRAVITY
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] line_x;
        logic [31:0] line_y;
        logic [15:0] cos_angle;
        logic [15:0] sin_angle;
        logic [31:0] extent_left;
        logic [30:0] extent_width;
        logic [25:0] ball_radius;
        logic [17:0] gravity;
    } t_cfg;

    typedef enum logic [1:0] {A_COS, A_SIN, A_BNC} t_asel;
    typedef enum logic [2:0] {B_X1, B_Y1, B_VX, B_VY, B_X2, B_Y2, B_VX1, B_VY1} t_bsel;
    typedef enum logic [1:0] {AC_NONE, AC_LOAD, AC_ADD, AC_SUB} t_accop;
    typedef enum logic [3:0] {
        D_NONE, D_Y2, D_X2, D_VX1, D_VY1, D_PX, D_PY, D_VX, D_VY
    } t_dest;

    typedef struct packed {
        t_asel  asel;
        t_bsel  bsel;
        t_accop acc;
        t_dest  dest;
        logic   bshift;
    } t_uop;

    typedef enum logic [2:0] {
        ST_IDLE, ST_GRAV, ST_MOVE, ST_SPAN, ST_ROT, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic grav;
        logic move;
        logic span;
        logic issue;
        logic flush;
        t_uop uop;
    } t_dp_ctl;

    typedef struct packed {
        logic span_hit;
        logic y2_done;
        logic y2_hit;
    } t_dp_sts;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_uop mk_uop(input t_asel a, input t_bsel b, input t_accop ac,
                                    input t_dest d, input logic bsh);
        t_uop u;
        u.asel   = a;
        u.bsel   = b;
        u.acc    = ac;
        u.dest   = d;
        u.bshift = bsh;
        return u;
    endfunction

    // rotate into line frame, bounce, rotate back
    function automatic t_uop uop_at(input logic [CNT_W-1:0] idx);
        t_uop u;
        unique case (idx)
            5'd0:    u = mk_uop(A_COS, B_Y1,  AC_LOAD, D_NONE, 1'b0);
            5'd1:    u = mk_uop(A_SIN, B_X1,  AC_SUB,  D_Y2,   1'b0);
            5'd2:    u = mk_uop(A_COS, B_X1,  AC_LOAD, D_NONE, 1'b0);
            5'd3:    u = mk_uop(A_SIN, B_Y1,  AC_ADD,  D_X2,   1'b0);
            5'd4:    u = mk_uop(A_COS, B_VX,  AC_LOAD, D_NONE, 1'b0);
            5'd5:    u = mk_uop(A_SIN, B_VY,  AC_ADD,  D_VX1,  1'b0);
            5'd6:    u = mk_uop(A_COS, B_VY,  AC_LOAD, D_NONE, 1'b0);
            5'd7:    u = mk_uop(A_SIN, B_VX,  AC_SUB,  D_VY1,  1'b0);
            5'd10:   u = mk_uop(A_BNC, B_VY1, AC_LOAD, D_VY1,  1'b1);
            5'd11:   u = mk_uop(A_COS, B_X2,  AC_LOAD, D_NONE, 1'b0);
            5'd12:   u = mk_uop(A_SIN, B_Y2,  AC_SUB,  D_PX,   1'b0);
            5'd13:   u = mk_uop(A_COS, B_Y2,  AC_LOAD, D_NONE, 1'b0);
            5'd14:   u = mk_uop(A_SIN, B_X2,  AC_ADD,  D_PY,   1'b0);
            5'd15:   u = mk_uop(A_COS, B_VX1, AC_LOAD, D_NONE, 1'b0);
            5'd16:   u = mk_uop(A_SIN, B_VY1, AC_SUB,  D_VX,   1'b0);
            5'd17:   u = mk_uop(A_COS, B_VY1, AC_LOAD, D_NONE, 1'b0);
            5'd18:   u = mk_uop(A_SIN, B_VX1, AC_ADD,  D_VY,   1'b0);
            default: u = mk_uop(A_COS, B_X1,  AC_NONE, D_NONE, 1'b0);
        endcase
        return u;
    endfunction

endpackage

// ===== hdl/ball_bounce_angled_line_step_unit.sv =====
// channel | signals                                   | word
// --------+-------------------------------------------+---------------------------------
// in      | s_axis_tvalid/tready/tdata/tuser          | load x,y,vx,vy; tuser = mode
// out     | m_axis_tvalid/tready/tdata/tuser          | pos x,y, vel x,y; tuser = bounced
// cfg     | i_cfg_valid/o_cfg_ready/index/data        | register index, value
//
// A load word is echoed. A tick runs gravity, move and span check; with overlap it
// rotates until y2 is written back, and with contact it runs 17 products through one
// shared 17x48 multiply-accumulate with a 3-stage issue/accumulate/writeback pipe.
// Synchronous active-low reset returns registers to defaults and ball state to zero.
// Input is not ready from acceptance until the result word is taken.
module ball_bounce_angled_line_step_unit
    import bbals_pkg::*;
#(
    parameter int POS_FRAC_BITS  = 16,
    parameter int TRIG_FRAC_BITS = 14
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [127:0]         s_axis_tdata,  // load_x, load_y, load_vx, load_vy
    input  logic [0:0]           s_axis_tuser,  // mode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [127:0]         m_axis_tdata,  // pos_x, pos_y, vel_x, vel_y
    output logic [0:0]           m_axis_tuser,  // bounced
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam logic [63:0] LX_RST  = 64'd50 << POS_FRAC_BITS;
    localparam logic [63:0] LY_RST  = 64'd200 << POS_FRAC_BITS;
    localparam logic [63:0] COS_RST = 64'd1 << TRIG_FRAC_BITS;
    localparam logic [63:0] WID_RST = 64'd300 << POS_FRAC_BITS;
    localparam logic [63:0] RAD_RST = 64'd40 << POS_FRAC_BITS;
    localparam logic [63:0] GRV_RST = (64'd2 << POS_FRAC_BITS) / 10;

    t_cfg    r_cfg;
    t_dp_ctl w_ctl;
    t_dp_sts w_sts;
    logic    w_in_acc, w_out_acc, w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_out_acc   = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_x       <= LX_RST[31:0];
            r_cfg.line_y       <= LY_RST[31:0];
            r_cfg.cos_angle    <= COS_RST[15:0];
            r_cfg.sin_angle    <= '0;
            r_cfg.extent_left  <= LX_RST[31:0];
            r_cfg.extent_width <= WID_RST[30:0];
            r_cfg.ball_radius  <= RAD_RST[25:0];
            r_cfg.gravity      <= GRV_RST[17:0];
        end else if (w_cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LINE_X:  r_cfg.line_x       <= i_cfg_data;
                CFG_LINE_Y:  r_cfg.line_y       <= i_cfg_data;
                CFG_COS:     r_cfg.cos_angle    <= i_cfg_data[15:0];
                CFG_SIN:     r_cfg.sin_angle    <= i_cfg_data[15:0];
                CFG_LEFT:    r_cfg.extent_left  <= i_cfg_data;
                CFG_WIDTH:   r_cfg.extent_width <= i_cfg_data[30:0];
                CFG_RADIUS:  r_cfg.ball_radius  <= i_cfg_data[25:0];
                CFG_GRAVITY: r_cfg.gravity      <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    bbals_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_acc    (w_in_acc),
        .i_mode      (s_axis_tuser[0]),
        .i_out_acc   (w_out_acc),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    bbals_dpath #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctl   (w_ctl),
        .i_load  (s_axis_tdata),
        .o_sts   (w_sts),
        .o_state (m_axis_tdata),
        .o_hit   (m_axis_tuser[0])
    );

endmodule

// ===== hdl/bbals_ctrl.sv =====
module bbals_ctrl
    import bbals_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_acc,
    input  logic    i_mode,
    input  logic    i_out_acc,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl,
    output logic    o_in_ready,
    output logic    o_out_valid
);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_UOPS + 1);
    localparam logic [CNT_W-1:0] ISSUE_END = CNT_W'(NUM_UOPS);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_ctl       = '0;
        o_ctl.uop   = uop_at(r_cnt);
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_acc) begin
                    o_ctl.load = i_mode;
                    n_state    = i_mode ? ST_OUT : ST_GRAV;
                end
            end
            ST_GRAV: begin
                o_ctl.grav = 1'b1;
                n_state    = ST_MOVE;
            end
            ST_MOVE: begin
                o_ctl.move = 1'b1;
                n_state    = ST_SPAN;
            end
            ST_SPAN: begin
                o_ctl.span = 1'b1;
                n_cnt      = '0;
                n_state    = i_sts.span_hit ? ST_ROT : ST_OUT;
            end
            ST_ROT: begin
                o_ctl.issue = (r_cnt < ISSUE_END);
                if (i_sts.y2_done && !i_sts.y2_hit) begin
                    // ball above the line: drop the rest of the sequence
                    o_ctl.flush = 1'b1;
                    n_state     = ST_OUT;
                end else if (r_cnt == LAST_CNT) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_acc) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/bbals_dpath.sv =====
module bbals_dpath
    import bbals_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 14
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  t_dp_ctl      i_ctl,
    input  logic [127:0] i_load,
    output t_dp_sts      o_sts,
    output logic [127:0] o_state,
    output logic         o_hit
);

    localparam logic signed [ACC_W-1:0] HALF_T = ACC_W'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_B = ACC_W'(1) <<< (BOUNCE_FRAC - 1);

    logic signed [31:0]       r_px, r_py, r_vx, r_vy;
    logic                     r_hit;
    logic signed [OPB_W-1:0]  r_x1, r_y1, r_x2, r_y2, r_vx1, r_vy1;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    t_uop                     r_s1_uop, r_s2_uop;
    logic                     r_s1_v, r_s2_v;

    logic signed [15:0]       w_cos, w_sin;
    logic signed [OPA_W-1:0]  w_a;
    logic signed [OPB_W-1:0]  w_b;
    logic signed [ACC_W-1:0]  w_prod, w_half, w_shift, w_neg_r, w_px_sum, w_py_sum;
    logic signed [34:0]       w_pxe, w_rad, w_left, w_right;
    logic                     w_wb, w_y2_hit;

    assign w_cos = $signed(i_cfg.cos_angle);
    assign w_sin = $signed(i_cfg.sin_angle);

    always_comb begin
        case (i_ctl.uop.asel)
            A_COS:   w_a = OPA_W'(w_cos);
            A_SIN:   w_a = OPA_W'(w_sin);
            default: w_a = BOUNCE_COEF;
        endcase
        case (i_ctl.uop.bsel)
            B_X1:    w_b = r_x1;
            B_Y1:    w_b = r_y1;
            B_VX:    w_b = OPB_W'(r_vx);
            B_VY:    w_b = OPB_W'(r_vy);
            B_X2:    w_b = r_x2;
            B_Y2:    w_b = r_y2;
            B_VX1:   w_b = r_vx1;
            default: w_b = r_vy1;
        endcase
    end

    assign w_prod  = ACC_W'(r_prod);
    assign w_half  = r_s1_uop.bshift ? HALF_B : HALF_T;
    assign w_shift = r_s2_uop.bshift ? (r_acc >>> BOUNCE_FRAC) : (r_acc >>> TRIG_FRAC_BITS);
    assign w_neg_r = -$signed({{(ACC_W-26){1'b0}}, i_cfg.ball_radius});
    assign w_y2_hit = (w_shift > w_neg_r);
    assign w_wb    = r_s2_v && (r_s2_uop.dest != D_NONE);
    assign w_px_sum = ACC_W'($signed(i_cfg.line_x)) + w_shift;
    assign w_py_sum = ACC_W'($signed(i_cfg.line_y)) + w_shift;

    assign w_pxe   = 35'(r_px);
    assign w_rad   = $signed({9'b0, i_cfg.ball_radius});
    assign w_left  = 35'($signed(i_cfg.extent_left));
    assign w_right = w_left + $signed({4'b0, i_cfg.extent_width});

    assign o_sts.span_hit = (w_pxe + w_rad > w_left) && (w_pxe - w_rad < w_right);
    assign o_sts.y2_done  = r_s2_v && (r_s2_uop.dest == D_Y2);
    assign o_sts.y2_hit   = w_y2_hit;

    assign o_state = {r_vy, r_vx, r_py, r_px};
    assign o_hit   = r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px   <= '0;
            r_py   <= '0;
            r_vx   <= '0;
            r_vy   <= '0;
            r_hit  <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_ctl.issue && !i_ctl.flush;
            r_s2_v <= r_s1_v && !i_ctl.flush;
            if (i_ctl.load) begin
                r_px  <= $signed(i_load[31:0]);
                r_py  <= $signed(i_load[63:32]);
                r_vx  <= $signed(i_load[95:64]);
                r_vy  <= $signed(i_load[127:96]);
                r_hit <= 1'b0;
            end
            if (i_ctl.grav) begin
                r_vy  <= sat32(ACC_W'(r_vy) + ACC_W'($signed(i_cfg.gravity)));
                r_hit <= 1'b0;
            end
            if (i_ctl.move) begin
                r_px <= sat32(ACC_W'(r_px) + ACC_W'(r_vx));
                r_py <= sat32(ACC_W'(r_py) + ACC_W'(r_vy));
            end
            if (w_wb) begin
                case (r_s2_uop.dest)
                    D_Y2: begin
                        r_y2  <= w_y2_hit ? w_neg_r[OPB_W-1:0] : w_shift[OPB_W-1:0];
                        r_hit <= w_y2_hit;
                    end
                    D_X2:    r_x2  <= w_shift[OPB_W-1:0];
                    D_VX1:   r_vx1 <= w_shift[OPB_W-1:0];
                    D_VY1:   r_vy1 <= w_shift[OPB_W-1:0];
                    D_PX:    r_px  <= sat32(w_px_sum);
                    D_PY:    r_py  <= sat32(w_py_sum);
                    D_VX:    r_vx  <= sat32(w_shift);
                    D_VY:    r_vy  <= sat32(w_shift);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.span) begin
            r_x1 <= OPB_W'(ACC_W'(r_px) - ACC_W'($signed(i_cfg.line_x)));
            r_y1 <= OPB_W'(ACC_W'(r_py) - ACC_W'($signed(i_cfg.line_y)));
        end
        r_prod   <= w_a * w_b;
        r_s1_uop <= i_ctl.uop;
        r_s2_uop <= r_s1_uop;
        if (r_s1_v) begin
            case (r_s1_uop.acc)
                AC_LOAD: r_acc <= w_prod + w_half;
                AC_ADD:  r_acc <= r_acc + w_prod;
                AC_SUB:  r_acc <= r_acc - w_prod;
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/bbals_chk.sv =====
module bbals_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [127:0] s_axis_tdata,
    input logic [0:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result word dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accept");

    a_load_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=>
            m_axis_tvalid && !m_axis_tuser[0] && (m_axis_tdata == $past(s_axis_tdata)))
        else $error("load word not echoed");

endmodule

bind ball_bounce_angled_line_step_unit bbals_chk u_bbals_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
